FILE: rtl/mpv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpv_pkg: shared types and constants
// Request fields, result fields and hash constants for the Merkle path checker.
// ----------------------------------------------------------------------------
package mpv_pkg;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] hash_value;
    logic [31:0] expected_root;
    logic        sibling_is_right;
    logic        last;
  } req_t;

  typedef struct packed {
    logic        match;
    logic [31:0] computed_root;
  } rsp_t;

  localparam logic [31:0] MUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2 = 32'h1b873593;
  localparam logic [31:0] MUR_N  = 32'he6546b64;
  localparam logic [31:0] MUR_F1 = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2 = 32'hc2b2ae35;
  localparam int unsigned DIGITS = 10;

endpackage
`default_nettype wire

FILE: rtl/mpv_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpv_req_if: request channel
// Valid/ready handshake carrying one proof item.
// ----------------------------------------------------------------------------
interface mpv_req_if;
  import mpv_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mpv_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpv_rsp_if: result channel
// Valid/ready handshake carrying one proof verdict.
// ----------------------------------------------------------------------------
interface mpv_rsp_if;
  import mpv_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/merkle_path_verify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// merkle_path_verify: Merkle inclusion proof checker
// Combines sibling hashes by decimal text and the 32-bit Murmur3 hash.
// ----------------------------------------------------------------------------
// A begin request loads the running hash and the target root; when it is
// flagged last it passes through the final state to give a result. A step
// request writes the right hash and then the left hash as decimal digits, one
// digit per cycle from a reciprocal divide-by-ten unit, stopping at the
// leading digit. It then runs the Murmur blocks, the tail and the finalizer
// through one shared 32x32 multiplier, and updates the running hash in the
// final state; the text length of the two hashes sets how long a step takes.
// The block takes no request while a step is in work. A finished result
// waits in the output register while the next request is taken; a later
// result holds in the final state until that register is free.
module merkle_path_verify (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata,
  mpv_req_if.sink     req,
  mpv_rsp_if.source   rsp
);
  import mpv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIGIT = 6'b000010,
    S_BLOCK = 6'b000100,
    S_TAIL  = 6'b001000,
    S_FIN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t      state;
  logic [31:0] hash_seed;
  logic [31:0] running_hash;
  logic [31:0] target_root;
  logic        last_q;
  logic        rsp_load;

  // digit buffers: text is built from least significant digit
  logic [3:0]  dig [20];
  logic [4:0]  len;
  logic [31:0] div_val;
  logic [3:0]  dig_cnt;
  logic [4:0]  wr_pos;
  logic        second;
  logic [31:0] right_word;
  logic [4:0]  left_len;

  // murmur
  logic [31:0] h;
  logic [31:0] k;
  logic [4:0]  byte_pos;
  logic [2:0]  sub;

  // divide by ten via reciprocal
  logic [63:0] prod10;
  logic [31:0] quo;
  logic [3:0]  rem;
  assign prod10 = {32'd0, div_val} * 64'hcccccccd;
  assign quo    = {3'd0, prod10[63:35]};
  assign rem    = 4'(div_val - quo * 32'd10);

  // shared multiplier
  logic [31:0] mul_a, mul_b, mul_p;
  assign mul_p = mul_a * mul_b;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [7:0] chr(input logic [4:0] p);
    chr = {4'h3, dig[p]};
  endfunction

  logic [31:0] blk;
  always_comb begin
    blk = {chr(byte_pos + 5'd3), chr(byte_pos + 5'd2), chr(byte_pos + 5'd1),
           chr(byte_pos)};
  end

  logic [31:0] tail_k;
  always_comb begin
    tail_k = '0;
    case (len[1:0])
      2'd3: tail_k = {8'd0, chr(byte_pos + 5'd2), chr(byte_pos + 5'd1), chr(byte_pos)};
      2'd2: tail_k = {16'd0, chr(byte_pos + 5'd1), chr(byte_pos)};
      2'd1: tail_k = {24'd0, chr(byte_pos)};
      default: tail_k = '0;
    endcase
  end

  always_comb begin
    mul_a = k;
    mul_b = MUR_C1;
    unique case (state)
      S_BLOCK, S_TAIL: begin
        unique case (sub)
          3'd0: begin mul_a = (state == S_BLOCK) ? blk : tail_k; mul_b = MUR_C1; end
          3'd1: begin mul_a = rotl(k, 15); mul_b = MUR_C2; end
          default: begin mul_a = h; mul_b = 32'd5; end
        endcase
      end
      S_FIN: begin
        mul_a = h;
        mul_b = (sub == 3'd1) ? MUR_F1 : MUR_F2;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && last_q && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hash_seed    <= '0;
      running_hash <= '0;
      target_root  <= '0;
      rsp.valid    <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we) hash_seed <= cfg_wdata;
      if (rsp_load) begin
        rsp.valid              <= 1'b1;
        rsp.data.match         <= h == target_root;
        rsp.data.computed_root <= h;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            last_q <= req.data.last;
            if (req.data.op == OP_BEGIN) begin
              running_hash <= req.data.hash_value;
              target_root  <= req.data.expected_root;
              h            <= req.data.hash_value;
              if (req.data.last) state <= S_DONE;
            end else begin
              // right part first, written backward from position 19
              div_val    <= req.data.sibling_is_right ? req.data.hash_value : running_hash;
              right_word <= req.data.sibling_is_right ? running_hash : req.data.hash_value;
              // note: right_word holds the left word (second to convert)
              dig_cnt    <= '0;
              wr_pos     <= 5'd19;
              second     <= 1'b0;
              len        <= '0;
              state      <= S_DIGIT;
            end
          end
        end
        S_DIGIT: begin
          dig[wr_pos] <= rem;
          len         <= len + 5'd1;
          wr_pos      <= wr_pos - 5'd1;
          if (quo == 32'd0 || dig_cnt == 4'(DIGITS - 1)) begin
            if (!second) begin
              second  <= 1'b1;
              div_val <= right_word;
              dig_cnt <= '0;
            end else begin
              byte_pos <= wr_pos;
              h        <= hash_seed;
              sub      <= '0;
              state    <= ((len + 5'd1) >= 5'd4) ? S_BLOCK : S_TAIL;
            end
          end else begin
            div_val <= quo;
            dig_cnt <= dig_cnt + 4'd1;
          end
        end
        S_BLOCK: begin
          unique case (sub)
            3'd0: begin
              k   <= mul_p;
              sub <= 3'd1;
            end
            3'd1: begin
              k   <= mul_p;
              h   <= rotl(h ^ mul_p, 13);
              sub <= 3'd2;
            end
            default: begin
              h        <= mul_p + MUR_N;
              sub      <= '0;
              byte_pos <= byte_pos + 5'd4;
              if ((5'd20 - byte_pos - 5'd4) < 5'd4) state <= S_TAIL;
            end
          endcase
        end
        S_TAIL: begin
          if (len[1:0] == 2'd0) begin
            h     <= h ^ {27'd0, len};
            sub   <= '0;
            state <= S_FIN;
          end else if (sub == 3'd0) begin
            k   <= mul_p;
            sub <= 3'd1;
          end else begin
            h     <= h ^ mul_p ^ {27'd0, len};
            sub   <= '0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (sub == 3'd0) begin
            h   <= (h ^ (h >> 16));
            sub <= 3'd1;
          end else if (sub == 3'd1) begin
            h   <= mul_p ^ (mul_p >> 13);
            sub <= 3'd2;
          end else if (sub == 3'd2) begin
            h   <= mul_p ^ (mul_p >> 16);
            sub <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          running_hash <= h;
          if (!last_q || rsp_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_ok;
  assign unused_ok = ^prod10[34:0];

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT || state == S_FIN) |-> !req.ready)
    else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
    else $error("result dropped");

endmodule
`default_nettype wire
